// ----- design/pbc_pkg.sv -----
// Shared types and constants for the PKCS#1 v1.5 block framing checker.
// No dependencies; used by pbc_front and the pkcs1_v15_block_check top level.
`default_nettype none
package pbc_pkg;

    // width used for position, length and offset compares
    localparam int CW = 11;

    localparam logic CMD_HASH_LOAD = 1'b0;
    localparam logic CMD_BLOCK     = 1'b1;

    localparam logic CFG_KEY_LEN    = 1'b0;
    localparam logic CFG_DIGEST_LEN = 1'b1;

    localparam logic [7:0] BYTE_00 = 8'h00;
    localparam logic [7:0] BYTE_01 = 8'h01;
    localparam logic [7:0] BYTE_02 = 8'h02;
    localparam logic [7:0] BYTE_FF = 8'hFF;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_LENGTH   = 3'd1;
    localparam logic [2:0] STATUS_NO_LEAD  = 3'd2;
    localparam logic [2:0] STATUS_NO_SEP   = 3'd3;
    localparam logic [2:0] STATUS_FF_PAD   = 3'd4;
    localparam logic [2:0] STATUS_ZERO_PAD = 3'd5;
    localparam logic [2:0] STATUS_BAD_TYPE = 3'd6;
    localparam logic [2:0] STATUS_HASH     = 3'd7;

    // one block byte on its way to the hash compare stage
    typedef struct packed {
        logic       cmp;       // byte lies in the hash field
        logic       zero_exp;  // hash index beyond the store, expect 00
        logic       last;
        logic [2:0] code;      // framing status, STATUS_OK means decided by hash
        logic [7:0] btype;
        logic [7:0] data;
    } stage_t;

endpackage
`default_nettype wire

// ----- design/pbc_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module pbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- design/pbc_front.sv -----
// Front stage: byte position, type and framing flags, hash store addressing.
// Depends on pbc_pkg.
`default_nettype none
module pbc_front #(
    parameter int MAX_BLOCK_BYTES = 512,
    parameter int MAX_HASH_BYTES  = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [9:0]                        key_len,
    input  wire logic [6:0]                        digest_len,
    input  wire logic                              accept,
    input  wire logic                              command,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              last,
    output logic                                   ram_we,
    output logic                                   ram_re,
    output logic      [$clog2(MAX_HASH_BYTES)-1:0] ram_addr,
    output pbc_pkg::stage_t                        stage
);

    localparam int AW = $clog2(MAX_HASH_BYTES);
    localparam int HW = $clog2(MAX_HASH_BYTES + 1);
    localparam int PW = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CW = pbc_pkg::CW;

    logic [HW-1:0] hidx_reg, hidx_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    type_reg, type_next;
    logic          lead_reg, sep_reg, noff_reg, zero_reg, over_reg;
    logic          lead_next, sep_next, noff_next, zero_next, over_next;

    logic [CW-1:0] kl, hl, posw, hstart, sepw, idx, pos_after;
    logic          cfg_bad, over, is_block, hash_room, len_err;
    logic [7:0]    type_now;
    logic          lead_now, sep_now, noff_now, zero_now, over_now;

    always_comb
    begin
        kl        = CW'(key_len);
        hl        = CW'(digest_len);
        posw      = CW'(pos_reg);
        hstart    = kl - hl;
        sepw      = hstart - CW'(1);
        idx       = posw - hstart;
        cfg_bad   = kl < (hl + CW'(3));
        over      = posw >= CW'(MAX_BLOCK_BYTES);
        is_block  = command == pbc_pkg::CMD_BLOCK;
        hash_room = hidx_reg < HW'(MAX_HASH_BYTES);

        type_now = (!over && posw == CW'(1)) ? data_byte : type_reg;
        lead_now = lead_reg;
        sep_now  = sep_reg;
        noff_now = noff_reg;
        zero_now = zero_reg;
        over_now = over_reg | over;
        if (!over && !cfg_bad)
        begin
            if (posw == '0)
            begin
                lead_now = lead_reg | (data_byte != pbc_pkg::BYTE_00);
            end
            else if (posw >= CW'(2) && posw < sepw)
            begin
                noff_now = noff_reg | (data_byte != pbc_pkg::BYTE_FF);
                zero_now = zero_reg | (data_byte == pbc_pkg::BYTE_00);
            end
            else if (posw == sepw)
            begin
                sep_now = sep_reg | (data_byte != pbc_pkg::BYTE_00);
            end
        end

        pos_after = over ? posw : posw + CW'(1);
        len_err   = over_now || (pos_after != kl) || cfg_bad;

        stage.cmp      = !over && !cfg_bad && posw >= hstart && posw < kl;
        stage.zero_exp = idx >= CW'(MAX_HASH_BYTES);
        stage.last     = last;
        stage.btype    = type_now;
        stage.data     = data_byte;
        if (len_err)
            stage.code = pbc_pkg::STATUS_LENGTH;
        else if (lead_now)
            stage.code = pbc_pkg::STATUS_NO_LEAD;
        else if (sep_now)
            stage.code = pbc_pkg::STATUS_NO_SEP;
        else if (type_now == pbc_pkg::BYTE_01)
            stage.code = noff_now ? pbc_pkg::STATUS_FF_PAD : pbc_pkg::STATUS_OK;
        else if (type_now == pbc_pkg::BYTE_02)
            stage.code = zero_now ? pbc_pkg::STATUS_ZERO_PAD : pbc_pkg::STATUS_OK;
        else
            stage.code = pbc_pkg::STATUS_BAD_TYPE;

        ram_we   = accept && !is_block && hash_room;
        ram_re   = accept && is_block;
        ram_addr = is_block ? idx[AW-1:0] : hidx_reg[AW-1:0];

        hidx_next = hidx_reg;
        pos_next  = pos_reg;
        type_next = type_reg;
        lead_next = lead_reg;
        sep_next  = sep_reg;
        noff_next = noff_reg;
        zero_next = zero_reg;
        over_next = over_reg;
        if (accept && !is_block)
        begin
            if (last)
                hidx_next = '0;
            else if (hash_room)
                hidx_next = hidx_reg + HW'(1);
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_next  = '0;
                type_next = '0;
                lead_next = 1'b0;
                sep_next  = 1'b0;
                noff_next = 1'b0;
                zero_next = 1'b0;
                over_next = 1'b0;
            end
            else
            begin
                pos_next  = over ? pos_reg : pos_reg + PW'(1);
                type_next = type_now;
                lead_next = lead_now;
                sep_next  = sep_now;
                noff_next = noff_now;
                zero_next = zero_now;
                over_next = over_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidx_reg <= '0;
            pos_reg  <= '0;
            type_reg <= '0;
            lead_reg <= 1'b0;
            sep_reg  <= 1'b0;
            noff_reg <= 1'b0;
            zero_reg <= 1'b0;
            over_reg <= 1'b0;
        end
        else
        begin
            hidx_reg <= hidx_next;
            pos_reg  <= pos_next;
            type_reg <= type_next;
            lead_reg <= lead_next;
            sep_reg  <= sep_next;
            noff_reg <= noff_next;
            zero_reg <= zero_next;
            over_reg <= over_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/pbc_pkcs1_placeholder_unused.sv -----
`default_nettype none
`default_nettype wire

// ----- design/pkcs1_v15_block_check.sv -----
// Top level of the PKCS#1 v1.5 signature block framing checker.
// Depends on pbc_pkg, pbc_front and pbc_ram.
//
// Usage:
//   Input channel (in_valid/in_stall): command 0 items load the expected hash,
//   one byte each, last closing the load. Command 1 items deliver the decrypted
//   block one byte per item; the item with last set closes the block.
//   Output channel (out_valid/out_stall): one item (status, block_type) per
//   block, none for hash loads or inner block bytes.
//   Configuration: cfg_we writes key_len (index 0) or digest_len (index 1) from
//   cfg_data; write only while no block is in flight.
//   Throughput: one item per cycle while in_stall is low. The last block byte
//   and its hash store read enter the compare stage register, then the status
//   goes into the output register and out_valid rises.
//   A stalled result holds in the output register; inner block bytes keep
//   flowing, and input stalls only when a second finished block is waiting
//   behind it.
//   Reset clears position, type, flags, the hash load index and both stages;
//   the hash store keeps its contents and is undefined until loaded.
//   key_len and digest_len reset to 256 and 20.
`default_nettype none
module pkcs1_v15_block_check #(
    parameter int MAX_BLOCK_BYTES = 512,
    parameter int MAX_HASH_BYTES  = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [9:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       command,
    input  wire logic [7:0] data_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [2:0] status,
    output logic      [7:0] block_type
);

    localparam int AW = $clog2(MAX_HASH_BYTES);

    logic [9:0] key_len_reg;
    logic [6:0] digest_len_reg;

    logic            accept;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_rdata;
    pbc_pkg::stage_t stage;

    pbc_pkg::stage_t b_reg;
    logic            b_valid_reg, b_valid_next;
    logic            hash_err_reg, hash_err_next;
    logic            b_adv, hash_bad, hash_any;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] status_reg;
    logic [7:0] type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg    <= 10'd256;
            digest_len_reg <= 7'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbc_pkg::CFG_KEY_LEN:    key_len_reg    <= cfg_data;
                pbc_pkg::CFG_DIGEST_LEN: digest_len_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign b_adv    = b_valid_reg && !(b_reg.last && out_valid_reg && out_stall);
    assign in_stall = b_valid_reg && !b_adv;
    assign accept   = in_valid && !in_stall;

    pbc_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
        .MAX_HASH_BYTES (MAX_HASH_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_len   (key_len_reg),
        .digest_len(digest_len_reg),
        .accept    (accept),
        .command   (command),
        .data_byte (data_byte),
        .last      (last),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .stage     (stage)
    );

    pbc_ram #(
        .WIDTH(8),
        .DEPTH(MAX_HASH_BYTES)
    ) u_hash_ram (
        .clk  (clk),
        .we   (ram_we),
        .re   (ram_re),
        .addr (ram_addr),
        .wdata(data_byte),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        hash_bad = b_reg.cmp &&
                   (b_reg.zero_exp ? (b_reg.data != pbc_pkg::BYTE_00)
                                   : (b_reg.data != ram_rdata));
        hash_any = hash_err_reg | hash_bad;

        b_valid_next = b_valid_reg;
        if (ram_re)
            b_valid_next = 1'b1;
        else if (b_adv)
            b_valid_next = 1'b0;

        hash_err_next = hash_err_reg;
        if (b_adv)
            hash_err_next = b_reg.last ? 1'b0 : hash_any;

        out_valid_next = out_valid_reg && out_stall;
        if (b_adv && b_reg.last)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            hash_err_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            hash_err_reg  <= hash_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            b_reg <= stage;
        end
        if (b_adv && b_reg.last)
        begin
            if (b_reg.code != pbc_pkg::STATUS_OK)
                status_reg <= b_reg.code;
            else
                status_reg <= hash_any ? pbc_pkg::STATUS_HASH : pbc_pkg::STATUS_OK;
            type_reg <= b_reg.btype;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign block_type = type_reg;

endmodule
`default_nettype wire

// ----- tb/pkcs1_v15_block_check_tb.sv -----
// Self-checking bench for pkcs1_v15_block_check: a cycle-free predictor of the
// framing verdict, directed framing cases, then random blocks under idle/stall mixes.
// Depends on pbc_pkg and the pkcs1_v15_block_check top level.
module pkcs1_v15_block_check_tb;

    localparam int MAX_BLOCK = 512;
    localparam int MAX_HASH  = 64;
    localparam int HAW       = $clog2(MAX_HASH);

    typedef struct {
        logic [2:0] st;
        logic [7:0] bt;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [9:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       command;
    logic [7:0] data_byte;
    logic       last;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [7:0] block_type;

    // predictor state
    logic [9:0] key_len_m    = 10'd256;
    logic [6:0] digest_len_m = 7'd20;
    logic [7:0] hash_mem [MAX_HASH];
    int         load_idx   = 0;
    int         blk_pos    = 0;
    logic [7:0] seen_type  = 8'h00;
    logic       f_lead = 1'b0, f_sep = 1'b0, f_noff = 1'b0;
    logic       f_zero = 1'b0, f_hash = 1'b0, f_over = 1'b0;

    verdict_t   pending_verdicts [$];
    logic [7:0] frame_bytes [$];

    int in_idle_pct    = 0;
    int out_stall_pct  = 0;
    int items_sent     = 0;
    int blocks_sent    = 0;
    int mismatch_count = 0;
    int status_seen [8];

    pkcs1_v15_block_check dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .data_byte  (data_byte),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .block_type (block_type)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_framing(logic cmd, logic [7:0] b, logic lst);
        int         kl;
        int         hl;
        int         hstart;
        int         idx;
        logic [7:0] want;
        verdict_t   v;
        kl = int'(key_len_m);
        hl = int'(digest_len_m);
        if (cmd == pbc_pkg::CMD_HASH_LOAD)
        begin
            if (load_idx < MAX_HASH)
            begin
                hash_mem[HAW'(load_idx)] = b;
                load_idx++;
            end
            if (lst)
                load_idx = 0;
            return;
        end
        if (blk_pos >= MAX_BLOCK)
            f_over = 1'b1;
        else
        begin
            if (blk_pos == 1)
                seen_type = b;
            if (kl >= hl + 3)
            begin
                hstart = kl - hl;
                if (blk_pos == 0)
                    f_lead |= (b != pbc_pkg::BYTE_00);
                else if (blk_pos >= 2 && blk_pos < hstart - 1)
                begin
                    f_noff |= (b != pbc_pkg::BYTE_FF);
                    f_zero |= (b == pbc_pkg::BYTE_00);
                end
                else if (blk_pos == hstart - 1)
                    f_sep |= (b != pbc_pkg::BYTE_00);
                else if (blk_pos >= hstart && blk_pos < kl)
                begin
                    idx = blk_pos - hstart;
                    want = (idx < MAX_HASH) ? hash_mem[HAW'(idx)] : pbc_pkg::BYTE_00;
                    f_hash |= (b != want);
                end
            end
            blk_pos++;
        end
        if (!lst)
            return;
        v.bt = seen_type;
        if (f_over || blk_pos != kl || kl < hl + 3)
            v.st = pbc_pkg::STATUS_LENGTH;
        else if (f_lead)
            v.st = pbc_pkg::STATUS_NO_LEAD;
        else if (f_sep)
            v.st = pbc_pkg::STATUS_NO_SEP;
        else if (seen_type == pbc_pkg::BYTE_01 && f_noff)
            v.st = pbc_pkg::STATUS_FF_PAD;
        else if (seen_type == pbc_pkg::BYTE_02 && f_zero)
            v.st = pbc_pkg::STATUS_ZERO_PAD;
        else if (seen_type != pbc_pkg::BYTE_01 && seen_type != pbc_pkg::BYTE_02)
            v.st = pbc_pkg::STATUS_BAD_TYPE;
        else if (f_hash)
            v.st = pbc_pkg::STATUS_HASH;
        else
            v.st = pbc_pkg::STATUS_OK;
        pending_verdicts.push_back(v);
        blocks_sent++;
        blk_pos   = 0;
        seen_type = 8'h00;
        {f_lead, f_sep, f_noff, f_zero, f_hash, f_over} = '0;
    endfunction

    // receiver side
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        verdict_t oldest;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d block_type %02h", status, block_type);
            end
            else
            begin
                oldest = pending_verdicts.pop_front();
                status_seen[oldest.st]++;
                if (status !== oldest.st || block_type !== oldest.bt)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: status exp %0d got %0d, block_type exp %02h got %02h",
                                 oldest.st, status, oldest.bt, block_type);
                end
            end
        end
    end

    task automatic send_item(logic cmd, logic [7:0] b, logic lst);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= b;
        last      <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_framing(cmd, b, lst);
        items_sent++;
    endtask

    // hold off until every verdict is back, then let hash writes settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(int kl, int hl);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= pbc_pkg::CFG_KEY_LEN;
        cfg_data  <= kl[9:0];
        @(posedge clk);
        key_len_m = kl[9:0];
        cfg_index <= pbc_pkg::CFG_DIGEST_LEN;
        cfg_data  <= {3'b000, hl[6:0]};
        @(posedge clk);
        digest_len_m = hl[6:0];
        cfg_we <= 1'b0;
    endtask

    task automatic load_hash(int n);
        for (int i = 0; i < n; i++)
            send_item(pbc_pkg::CMD_HASH_LOAD, 8'($urandom), i == n - 1);
    endtask

    // well-formed block for the current registers, len bytes long
    function automatic void build_frame(int len, logic [7:0] btype);
        int         kl;
        int         hl;
        int         hstart;
        logic [7:0] v;
        kl = int'(key_len_m);
        hl = int'(digest_len_m);
        hstart = kl - hl;
        frame_bytes.delete();
        for (int p = 0; p < len; p++)
        begin
            if (kl < hl + 3)
                v = 8'($urandom);
            else if (p == 0)
                v = pbc_pkg::BYTE_00;
            else if (p == 1)
                v = btype;
            else if (p < hstart - 1)
            begin
                if (btype == pbc_pkg::BYTE_01)
                    v = pbc_pkg::BYTE_FF;
                else if (btype == pbc_pkg::BYTE_02)
                    v = 8'($urandom_range(1, 255));
                else
                    v = 8'($urandom);
            end
            else if (p == hstart - 1)
                v = pbc_pkg::BYTE_00;
            else if (p < kl)
                v = (p - hstart < MAX_HASH) ? hash_mem[HAW'(p - hstart)] : pbc_pkg::BYTE_00;
            else
                v = 8'($urandom);
            frame_bytes.push_back(v);
        end
    endfunction

    task automatic send_frame(bit noisy);
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            if (noisy && $urandom_range(99) < 2)
                send_item(pbc_pkg::CMD_HASH_LOAD, 8'($urandom), 1'($urandom));
            send_item(pbc_pkg::CMD_BLOCK, frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic framed_block(int len, logic [7:0] btype, int pos, logic [7:0] val);
        build_frame(len, btype);
        if (pos >= 0)
            frame_bytes[pos] = val;
        send_frame(1'b0);
    endtask

    // fills the whole store and runs past its end
    task automatic test_hash_load();
        load_hash(MAX_HASH + 2);
    endtask

    task automatic test_default_registers();
        framed_block(256, pbc_pkg::BYTE_01, -1, 8'h00);
    endtask

    // key length 8, hash length 2: separator at 5, padding 2..4, hash 6..7
    task automatic test_each_status();
        set_config(8, 2);
        framed_block(8, pbc_pkg::BYTE_01, -1, 8'h00);
        framed_block(8, pbc_pkg::BYTE_02, -1, 8'h00);
        framed_block(8, pbc_pkg::BYTE_01, 0, 8'h01);
        framed_block(8, pbc_pkg::BYTE_01, 5, 8'hFF);
        framed_block(8, pbc_pkg::BYTE_01, 3, 8'hFE);
        framed_block(8, pbc_pkg::BYTE_01, 3, 8'h00);
        framed_block(8, pbc_pkg::BYTE_02, 3, 8'h00);
        framed_block(8, pbc_pkg::BYTE_02, 3, 8'hFF);
        framed_block(8, 8'h00, -1, 8'h00);
        framed_block(8, 8'h03, -1, 8'h00);
        framed_block(8, 8'hFF, 7, 8'h5A);
        framed_block(8, pbc_pkg::BYTE_01, 7, ~hash_mem[1]);
        framed_block(7, pbc_pkg::BYTE_01, -1, 8'h00);
        framed_block(9, pbc_pkg::BYTE_01, -1, 8'h00);
        build_frame(8, pbc_pkg::BYTE_01);
        frame_bytes[0] = 8'hFF;
        frame_bytes[5] = 8'h01;
        send_frame(1'b0);
        framed_block(1, pbc_pkg::BYTE_01, -1, 8'h00);
        framed_block(2, pbc_pkg::BYTE_02, -1, 8'h00);
    endtask

    task automatic test_register_extremes();
        set_config(4, 1);
        framed_block(4, pbc_pkg::BYTE_01, -1, 8'h00);
        framed_block(4, pbc_pkg::BYTE_02, -1, 8'h00);
        framed_block(4, 8'h05, -1, 8'h00);
        framed_block(4, pbc_pkg::BYTE_01, 2, 8'hFF);
        set_config(4, 2);
        framed_block(4, pbc_pkg::BYTE_01, -1, 8'h00);
        set_config(0, 0);
        framed_block(1, pbc_pkg::BYTE_01, -1, 8'h00);
        // hash runs one byte past the store
        set_config(68, 65);
        framed_block(68, pbc_pkg::BYTE_01, -1, 8'h00);
        framed_block(68, pbc_pkg::BYTE_02, 67, 8'h5A);
    endtask

    task automatic random_config();
        int r;
        int kl;
        int hl;
        r = $urandom_range(99);
        if (r < 70)
        begin
            kl = $urandom_range(4, 24);
            hl = $urandom_range(1, kl - 3);
        end
        else if (r < 80)
        begin
            kl = $urandom_range(0, 12);
            hl = $urandom_range(0, 127);
        end
        else if (r < 96)
        begin
            hl = $urandom_range(65, 70);
            kl = hl + $urandom_range(3, 5);
        end
        else
        begin
            kl = $urandom_range(0, 60);
            hl = $urandom_range(0, 127);
        end
        set_config(kl, hl);
    endtask

    task automatic random_block();
        int         r;
        int         len;
        logic [7:0] t;
        r = $urandom_range(99);
        len = int'(key_len_m);
        if (r < 8)
            len = $urandom_range(1, 3);
        else if (r < 20)
            len = len + $urandom_range(0, 6) - 3;
        if (len < 1)
            len = 1;
        if (len > 520)
            len = 520;
        r = $urandom_range(99);
        t = (r < 45) ? pbc_pkg::BYTE_01 : (r < 85) ? pbc_pkg::BYTE_02 : 8'($urandom);
        build_frame(len, t);
        if ($urandom_range(99) < 30)
            frame_bytes[$urandom_range(len - 1)] = 8'($urandom);
        send_frame(1'b1);
    endtask

    task automatic run_phase(int idle, int stall, int n);
        int stop;
        int left;
        int r;
        in_idle_pct   = idle;
        out_stall_pct = stall;
        stop = items_sent + n;
        left = 0;
        while (items_sent < stop)
        begin
            if (left == 0)
            begin
                random_config();
                left = $urandom_range(2, 6);
            end
            r = $urandom_range(99);
            if (r < 8)
                load_hash($urandom_range(1, 70));
            else if (r < 12)
                drain();
            else
            begin
                random_block();
                left--;
            end
        end
        drain();
    endtask

    task automatic test_random();
        run_phase(0, 0, 40);
        run_phase(79, 0, 40);
        run_phase(0, 79, 40);
        run_phase(13, 13, 40);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= pbc_pkg::CFG_KEY_LEN;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        command   <= pbc_pkg::CMD_HASH_LOAD;
        data_byte <= '0;
        last      <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hash_load();
        test_default_registers();
        test_each_status();
        test_register_extremes();
        test_random();
        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d block verdicts from %0d input items, idle and stall mixes",
                 blocks_sent, items_sent);
        $display("verdict codes 0..7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- pkcs1_v15_block_check.f -----
design/pbc_pkg.sv
design/pbc_ram.sv
design/pbc_front.sv
design/pbc_pkcs1_placeholder_unused.sv
design/pkcs1_v15_block_check.sv
tb/pkcs1_v15_block_check_tb.sv
